>>> src/utf8sd_pkg.sv
package utf8sd_pkg;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_NUL   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [20:0] unit_value;
      kind_type    result_kind;
      logic        run_last;
      logic        string_done;
   } result_type;

   // Results produced by one input byte: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

>>> src/utf8sd_core.sv
module utf8sd_core
   import utf8sd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic [7:0]      data_byte,
   input  logic            end_of_buffer,
   input  logic            utf16_mode,
   output result_pair_type results
);

   localparam logic [30:0] CP_LIMIT     = 31'h110000;
   localparam logic [19:0] SURR_BLOCK   = 20'h0001B;
   localparam logic [30:0] NONCHAR_LO   = 31'h00FDD0;
   localparam logic [30:0] NONCHAR_HI   = 31'h00FDEF;
   localparam logic [14:0] NONCHAR_TAIL = 15'h7FFF;
   localparam logic [30:0] SUPP_BASE    = 31'h010000;
   localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
   localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;

   logic [30:0] acc_ff, acc_in;
   logic [2:0]  rem_ff, rem_in;
   logic [2:0]  len_ff, len_in;
   logic        disc_ff, disc_in;

   logic [30:0] acc_shift;
   logic [2:0]  rem_dec;
   logic [30:0] emit_cp;
   logic [2:0]  emit_len;
   logic [2:0]  short_len;
   logic        cp_ok;
   logic        emit_ok;
   logic [20:0] supp_off;
   logic [6:0]  lead_mask;
   logic [2:0]  lead_len;
   logic        do_emit;
   logic        do_fail;

   assign acc_shift = {acc_ff[24:0], data_byte[5:0]};
   assign rem_dec   = rem_ff - 3'd1;
   assign emit_cp   = (rem_ff == 3'd0) ? {23'd0, data_byte} : acc_shift;
   assign emit_len  = (rem_ff == 3'd0) ? 3'd1 : len_ff;

   always_comb begin
      if (emit_cp < 31'h80) begin
         short_len = 3'd1;
      end else if (emit_cp < 31'h800) begin
         short_len = 3'd2;
      end else if (emit_cp < 31'h10000) begin
         short_len = 3'd3;
      end else if (emit_cp < 31'h200000) begin
         short_len = 3'd4;
      end else if (emit_cp < 31'h4000000) begin
         short_len = 3'd5;
      end else begin
         short_len = 3'd6;
      end
   end

   assign cp_ok = (emit_cp < CP_LIMIT) &&
                  (emit_cp[30:11] != SURR_BLOCK) &&
                  !((emit_cp >= NONCHAR_LO) && (emit_cp <= NONCHAR_HI)) &&
                  (emit_cp[15:1] != NONCHAR_TAIL);
   assign emit_ok  = cp_ok && (short_len == emit_len);
   assign supp_off = emit_cp[20:0] - SUPP_BASE[20:0];

   always_comb begin
      if (data_byte[7:5] == 3'b110) begin
         lead_mask = 7'h1F;
         lead_len  = 3'd2;
      end else if (data_byte[7:4] == 4'b1110) begin
         lead_mask = 7'h0F;
         lead_len  = 3'd3;
      end else if (data_byte[7:3] == 5'b11110) begin
         lead_mask = 7'h07;
         lead_len  = 3'd4;
      end else if (data_byte[7:2] == 6'b111110) begin
         lead_mask = 7'h03;
         lead_len  = 3'd5;
      end else if (data_byte[7:1] == 7'b1111110) begin
         lead_mask = 7'h01;
         lead_len  = 3'd6;
      end else begin
         lead_mask = 7'h00;
         lead_len  = 3'd0;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      disc_in = disc_ff;
      do_emit = 1'b0;
      do_fail = 1'b0;
      results.count  = 2'd0;
      results.first  = '{unit_value: 21'd0, result_kind: KIND_ERROR,
                         run_last: 1'b1, string_done: 1'b1};
      results.second = results.first;

      if (disc_ff) begin
         if (end_of_buffer) begin
            disc_in = 1'b0;
         end
      end else if (rem_ff == 3'd0) begin
         if (!data_byte[7]) begin
            do_emit = 1'b1;
         end else if (lead_len == 3'd0 || end_of_buffer) begin
            do_fail = 1'b1;
         end else begin
            acc_in = {24'd0, data_byte[6:0] & lead_mask};
            rem_in = lead_len - 3'd1;
            len_in = lead_len;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         do_fail = 1'b1;
      end else begin
         acc_in = acc_shift;
         rem_in = rem_dec;
         if (rem_dec == 3'd0) begin
            do_emit = 1'b1;
         end else if (end_of_buffer) begin
            do_fail = 1'b1;
         end
      end

      if (do_fail || (do_emit && !emit_ok)) begin
         // Malformed input: one error item, then skip to the end of the buffer.
         acc_in        = '0;
         rem_in        = '0;
         len_in        = '0;
         disc_in       = !end_of_buffer;
         results.count = 2'd1;
      end else if (do_emit) begin
         acc_in = '0;
         rem_in = '0;
         len_in = '0;
         if (emit_cp == 31'd0) begin
            disc_in = !end_of_buffer;
            results.count             = 2'd1;
            results.first.result_kind = KIND_NUL;
         end else if (!utf16_mode || emit_cp < SUPP_BASE) begin
            results.count = 2'd1;
            results.first = '{unit_value: emit_cp[20:0], result_kind: KIND_DATA,
                              run_last: 1'b1, string_done: end_of_buffer};
         end else begin
            // Code points above the BMP become a surrogate pair.
            results.count  = 2'd2;
            results.first  = '{unit_value: {5'd0, HI_SURR_TAG, supp_off[19:10]},
                               result_kind: KIND_DATA,
                               run_last: 1'b0, string_done: 1'b0};
            results.second = '{unit_value: {5'd0, LO_SURR_TAG, supp_off[9:0]},
                               result_kind: KIND_DATA,
                               run_last: 1'b1, string_done: end_of_buffer};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         len_ff  <= '0;
         disc_ff <= 1'b0;
      end else if (fire) begin
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         len_ff  <= len_in;
         disc_ff <= disc_in;
      end
   end

endmodule

>>> src/utf8_stream_decoder.sv
// A byte taken on req_* is registered, decoded when it fires, and its result
// items go into the three-entry result queue and are offered on rsp_* from its head.
// The decoder takes one byte per cycle while at least two queue slots are free; a
// UTF-16 surrogate pair leaves as two items through the single result port.
// Reset (synchronous): clears the decode state, empties the queue, selects UCS-4.
module utf8_stream_decoder
   import utf8sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] unit_value, [23:21] zero
   output logic        rsp_tlast,   // run_last
   output logic [2:0]  rsp_tuser,   // [1:0] result_kind, [2] string_done
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // output_format
);

   logic            fmt_ff;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_eob_ff;
   logic            fire;
   logic            pop;
   result_pair_type results;

   result_type      q_ff [3];
   result_type      q_in [3];
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      cnt_shift;

   // An item is decoded only when at least two queue slots are free, so the
   // input side never waits on rsp_tready within the same cycle.
   assign fire       = in_valid_ff && !cnt_ff[1] && (cnt_ff != 2'd3);
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   utf8sd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .utf16_mode    (fmt_ff),
      .results       (results)
   );

   always_comb begin
      cnt_shift = cnt_ff - {1'b0, pop};
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         q_in[2] = q_ff[2];
      end else begin
         q_in = q_ff;
      end
      cnt_in = cnt_shift;
      if (fire) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) == cnt_shift && results.count != 2'd0) begin
               q_in[i] = results.first;
            end
            if (2'(i) == cnt_shift + 2'd1 && results.count == 2'd2) begin
               q_in[i] = results.second;
            end
         end
         cnt_in = cnt_shift + results.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= 1'b0;
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            fmt_ff <= csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
      q_ff <= q_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {3'd0, q_ff[0].unit_value};
   assign rsp_tlast  = q_ff[0].run_last;
   assign rsp_tuser  = {q_ff[0].string_done, q_ff[0].result_kind};

endmodule

>>> dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8sd_pkg::*;

   localparam int N_DIRECTED = 28;
   localparam int DIRECTED_SPLIT = 19;
   localparam int PHASE_ITEMS = 250;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_QUIET,
      CHK_TYPED
   } check_mode_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           eob;
      check_mode_type mode;
      logic [20:0]    value;
      kind_type       kind;
      logic           done;
   } byte_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // Decoder state as the testbench sees it.
   logic [30:0] acc_bits = '0;
   logic [2:0]  cont_left = '0;
   logic [2:0]  seq_len = '0;
   logic        skipping = 1'b0;
   logic        fmt_utf16 = 1'b0;

   result_type   made [2];
   int           made_n;
   result_type   pending_units [$];
   byte_row_type stim_q [$];
   logic [7:0]   seq_bytes [$];

   int mismatches = 0;
   int items_in = 0;
   int units_out = 0;
   int n_errors = 0;
   int n_nuls = 0;
   int n_pairs = 0;

   // Directed bytes. Typed rows carry their single expected result; the
   // surrogate pair row is left to the decoder model.
   byte_row_type directed_rows [N_DIRECTED] = '{
      '{8'hF0, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h9F, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h98, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b0, CHK_TYPED, 21'h1F600, KIND_DATA,  1'b0},
      '{8'h00, 1'b0, CHK_TYPED, 21'h0,     KIND_NUL,   1'b1},
      '{8'h41, 1'b1, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h7F, 1'b1, CHK_TYPED, 21'h7F,    KIND_DATA,  1'b1},
      '{8'h80, 1'b0, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hFE, 1'b1, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'hC0, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hED, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'hA0, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hE2, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h41, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hE2, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h82, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hC3, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1},
      '{8'hF4, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h8F, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'hBF, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'hBD, 1'b1, CHK_MODEL, 21'h0,     KIND_DATA,  1'b0},
      '{8'hF8, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h88, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b0, CHK_QUIET, 21'h0,     KIND_DATA,  1'b0},
      '{8'h80, 1'b1, CHK_TYPED, 21'h0,     KIND_ERROR, 1'b1}
   };

   utf8_stream_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5ns clock = ~clock;

   function automatic void add_unit(logic [20:0] v, kind_type k, logic l, logic d);
      made[made_n] = '{unit_value: v, result_kind: k, run_last: l, string_done: d};
      made_n++;
   endfunction

   function automatic void raise_error(logic eob);
      acc_bits = '0;
      cont_left = '0;
      seq_len = '0;
      skipping = !eob;
      add_unit(21'h0, KIND_ERROR, 1'b1, 1'b1);
   endfunction

   // A sequence is complete: range, surrogate, noncharacter and overlong checks.
   function automatic void close_sequence(logic [30:0] cp, logic [2:0] len, logic eob);
      logic [2:0]  shortest;
      logic        legal;
      logic [30:0] off;
      acc_bits = '0;
      cont_left = '0;
      seq_len = '0;
      if (cp < 31'h80) shortest = 3'd1;
      else if (cp < 31'h800) shortest = 3'd2;
      else if (cp < 31'h10000) shortest = 3'd3;
      else if (cp < 31'h200000) shortest = 3'd4;
      else if (cp < 31'h4000000) shortest = 3'd5;
      else shortest = 3'd6;
      legal = cp < 31'h110000 && ({1'b0, cp} & 32'hFFFF_F800) != 32'hD800 &&
              (cp < 31'hFDD0 || cp > 31'hFDEF) && cp[15:1] != 15'h7FFF;
      if (!legal || shortest != len) begin
         raise_error(eob);
      end else if (cp == 31'h0) begin
         skipping = !eob;
         add_unit(21'h0, KIND_NUL, 1'b1, 1'b1);
      end else if (!fmt_utf16 || cp < 31'h10000) begin
         add_unit(cp[20:0], KIND_DATA, 1'b1, eob);
      end else begin
         off = cp - 31'h10000;
         add_unit(21'hD800 + 21'(off[19:10]), KIND_DATA, 1'b0, 1'b0);
         add_unit(21'hDC00 + 21'(off[9:0]), KIND_DATA, 1'b1, eob);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eob);
      logic [7:0] mask;
      logic [2:0] len;
      made_n = 0;
      mask = 8'h00;
      len = 3'd0;
      if (skipping) begin
         if (eob) skipping = 1'b0;
      end else if (cont_left == 3'd0) begin
         if (b < 8'h80) begin
            close_sequence({23'h0, b}, 3'd1, eob);
         end else begin
            if (b[7:5] == 3'b110) begin
               mask = 8'h1F;
               len = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
               mask = 8'h0F;
               len = 3'd3;
            end else if (b[7:3] == 5'b11110) begin
               mask = 8'h07;
               len = 3'd4;
            end else if (b[7:2] == 6'b111110) begin
               mask = 8'h03;
               len = 3'd5;
            end else if (b[7:1] == 7'b1111110) begin
               mask = 8'h01;
               len = 3'd6;
            end
            // A lead byte that is bad, or that ends the buffer, is an error.
            if (len == 3'd0 || eob) begin
               raise_error(eob);
            end else begin
               acc_bits = {23'h0, b & mask};
               cont_left = len - 3'd1;
               seq_len = len;
            end
         end
      end else if (b[7:6] != 2'b10) begin
         raise_error(eob);
      end else begin
         acc_bits = {acc_bits[24:0], b[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 3'd0) close_sequence(acc_bits, seq_len, eob);
         else if (eob) raise_error(eob);
      end
   endfunction

   function automatic void encode_seq(logic [30:0] cp, int len);
      logic [7:0] lead;
      seq_bytes.delete();
      if (len == 1) begin
         seq_bytes.push_back(cp[7:0]);
      end else begin
         lead = (8'hFF << (8 - len)) | (8'(cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
         seq_bytes.push_back(lead);
         for (int k = len - 2; k >= 0; k--) begin
            seq_bytes.push_back(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
         end
      end
   endfunction

   function automatic logic [30:0] cp_for_length(int n);
      case (n)
         1: return 31'($urandom_range(0, 'h7F));
         2: return 31'($urandom_range('h80, 'h7FF));
         3: return 31'($urandom_range('h800, 'hFFFF));
         default: return 31'($urandom_range('h10000, 'h10FFFF));
      endcase
   endfunction

   // One string: mostly well formed sequences, some invalid values, overlong
   // forms, noise bytes, broken continuations and cut-off tails.
   task automatic add_string();
      logic [7:0]  s [$];
      logic [30:0] cp;
      logic [1:0]  top;
      int          pieces;
      int          cat;
      int          len;
      int          base;
      int          cut;
      bit          cut_off;
      pieces = $urandom_range(1, 6);
      cut_off = 1'b0;
      for (int k = 0; k < pieces && !cut_off; k++) begin
         cat = $urandom_range(0, 99);
         len = 1;
         if (cat < 30) begin
            cp = 31'($urandom_range(1, 'h7F));
         end else if (cat < 75) begin
            base = cat < 45 ? 2 : (cat < 60 ? 3 : 4);
            cp = cp_for_length(base);
            len = base;
         end else if (cat < 82) begin
            case ($urandom_range(0, 3))
               0: begin
                  cp = 31'($urandom_range('hD800, 'hDFFF));
                  len = 3;
               end
               1: begin
                  cp = 31'($urandom_range('hFDD0, 'hFDEF));
                  len = 3;
               end
               2: begin
                  cp = {10'h0, 5'($urandom_range(0, 16)), 15'h7FFF, 1'($urandom)};
                  len = cp < 31'h10000 ? 3 : 4;
               end
               default: begin
                  cp = 31'($urandom_range('h110000, 'h1FFFFF));
                  len = 4;
               end
            endcase
         end else if (cat < 86) begin
            cp = 31'h0;
         end else if (cat < 92) begin
            base = $urandom_range(1, 4);
            cp = cp_for_length(base);
            len = base + $urandom_range(1, 2);
         end else if (cat < 95) begin
            len = $urandom_range(5, 6);
            cp = len == 5 ? 31'($urandom_range(0, 'h3FFFFFF)) : 31'($urandom);
         end else begin
            cp = 31'($urandom_range(0, 255));
         end
         encode_seq(cp, len);
         if (seq_bytes.size() > 1) begin
            cat = $urandom_range(0, 99);
            if (cat < 4) begin
               top = 2'($urandom_range(0, 2));
               if (top == 2'b10) top = 2'b11;
               seq_bytes[$urandom_range(1, seq_bytes.size() - 1)] = {top, 6'($urandom)};
            end else if (cat < 8) begin
               cut = $urandom_range(1, seq_bytes.size() - 1);
               while (seq_bytes.size() > cut) void'(seq_bytes.pop_back());
               cut_off = 1'b1;
            end
         end
         foreach (seq_bytes[j]) s.push_back(seq_bytes[j]);
      end
      foreach (s[j]) begin
         stim_q.push_back('{data: s[j], eob: j == s.size() - 1, mode: CHK_MODEL,
                            value: 21'h0, kind: KIND_DATA, done: 1'b0});
      end
   endtask

   task automatic offer_row(byte_row_type row);
      while (!(items_in >= 500 && items_in < 700) && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.data;
      req_tlast <= row.eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // The decoder state advances on every byte, typed or not.
      decode_byte(row.data, row.eob);
      case (row.mode)
         CHK_MODEL: for (int k = 0; k < made_n; k++) pending_units.push_back(made[k]);
         CHK_TYPED: pending_units.push_back('{unit_value: row.value, result_kind: row.kind,
                                              run_last: 1'b1, string_done: row.done});
         default: ;
      endcase
      items_in++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_units.size() != 0) @(posedge clock);
      // A byte that makes no result may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(logic fmt);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fmt_utf16 = fmt;
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatches < 50) begin
         $display("%0t: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                  $time, field, units_out, got, want);
      end
      mismatches++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (i == DIRECTED_SPLIT) write_format(1'b1);
         offer_row(directed_rows[i]);
      end
      for (int p = 0; p < 4; p++) begin
         write_format(p[0]);
         stim_q.delete();
         while (stim_q.size() < PHASE_ITEMS) add_string();
         foreach (stim_q[j]) offer_row(stim_q[j]);
      end
      drain();
      $display("Sent %0d bytes and checked %0d results: %0d errors, %0d NUL stops, %0d pairs.",
               items_in, units_out, n_errors, n_nuls, n_pairs);
      $display("Both output formats were used, with random gaps and one long output stall.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_units.size() == 0) begin
            report_mismatch("unexpected result, unit_value", {8'h0, rsp_tdata}, 32'h0);
         end else begin
            want = pending_units.pop_front();
            if (rsp_tdata[20:0] !== want.unit_value)
               report_mismatch("unit_value", 32'(rsp_tdata[20:0]), 32'(want.unit_value));
            if (rsp_tuser[1:0] !== want.result_kind)
               report_mismatch("result_kind", 32'(rsp_tuser[1:0]), 32'(want.result_kind));
            if (rsp_tlast !== want.run_last)
               report_mismatch("run_last", 32'(rsp_tlast), 32'(want.run_last));
            if (rsp_tuser[2] !== want.string_done)
               report_mismatch("string_done", 32'(rsp_tuser[2]), 32'(want.string_done));
            if (want.result_kind == KIND_ERROR) n_errors++;
            if (want.result_kind == KIND_NUL) n_nuls++;
            if (!want.run_last) n_pairs++;
         end
         units_out++;
      end
   end

   // Output side: random back-pressure, a calm window, and one long hold-off
   // that lets the decoder fill up and stall its input.
   int taken = 0;
   int hold_left = 0;
   bit held = 1'b0;

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) taken++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held && taken >= 200) begin
         held = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (taken >= 600 && taken < 800) || $urandom_range(0, 99) >= 21;
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

endmodule

>>> filelist.f
src/utf8sd_pkg.sv
src/utf8sd_core.sv
src/utf8_stream_decoder.sv
dv/tb_top.sv
